// ----- rtl/sbhs_pkg.sv -----
// Package: shared constants, payload types, opcodes and state enums for the rank unit.
package sbhs_pkg;

    localparam int MAX_BUCKETS_DEF      = 64;
    localparam int SLOTS_PER_BUCKET_DEF = 8;
    localparam int KEY_BITS_DEF         = 32;

    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 9;
    localparam int NB_W     = 7;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [KEY_W-1:0]    key;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RANK_W-1:0]   rank;
    } out_item_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SCAN_RD,
        BK_SCAN_CHK,
        BK_DECIDE,
        BK_INS_RD,
        BK_INS_WR,
        BK_DEL_RD,
        BK_DEL_WR,
        BK_PUT,
        BK_SUM,
        BK_OUT
    } back_state_t;

endpackage

// ----- rtl/sbhs_front.sv -----
// Front end: accepts items, masks the key and finds its bucket by restoring division.
module sbhs_front #(
    parameter int MAX_BUCKETS = sbhs_pkg::MAX_BUCKETS_DEF,
    parameter int KEY_BITS    = sbhs_pkg::KEY_BITS_DEF,
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    localparam int KW = (KEY_BITS < sbhs_pkg::KEY_W) ? KEY_BITS : sbhs_pkg::KEY_W,
    localparam int KCW = $clog2(KW + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sbhs_pkg::in_item_t          in_data,
    input  logic [sbhs_pkg::NB_W-1:0]   nb,
    output logic                        q_valid,
    input  logic                        q_ready,
    output logic [sbhs_pkg::OPCODE_W-1:0] q_op,
    output logic [KW-1:0]               q_key,
    output logic [BW-1:0]               q_bucket
);

    localparam int DW = BW + 1;

    sbhs_pkg::front_state_t state_reg, state_next;
    logic [sbhs_pkg::OPCODE_W-1:0] op_reg;
    logic [KW-1:0]  key_reg;
    logic [KW-1:0]  quo_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  div_reg;
    logic [KCW-1:0] cnt_reg;
    logic [DW:0]    trial;
    logic [DW-1:0]  eff;

    always_comb
    begin
        if (nb == '0)
            eff = DW'(1);
        else if ({{(32-sbhs_pkg::NB_W){1'b0}}, nb} > 32'(MAX_BUCKETS))
            eff = DW'(MAX_BUCKETS);
        else
            eff = DW'(nb);
    end

    assign trial = {rem_reg, quo_reg[KW-1]} - {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbhs_pkg::FR_IDLE: if (in_valid) state_next = sbhs_pkg::FR_DIV;
            sbhs_pkg::FR_DIV:  if (cnt_reg == KCW'(KW - 1)) state_next = sbhs_pkg::FR_PUSH;
            sbhs_pkg::FR_PUSH: if (q_ready) state_next = sbhs_pkg::FR_IDLE;
            default:           state_next = sbhs_pkg::FR_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == sbhs_pkg::FR_IDLE);
        q_valid  = (state_reg == sbhs_pkg::FR_PUSH);
    end

    assign q_op     = op_reg;
    assign q_key    = key_reg;
    assign q_bucket = BW'(rem_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sbhs_pkg::FR_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sbhs_pkg::FR_IDLE && in_valid)
        begin
            op_reg  <= in_data.opcode;
            key_reg <= in_data.key[KW-1:0];
            quo_reg <= in_data.key[KW-1:0];
            rem_reg <= '0;
            div_reg <= eff;
            cnt_reg <= '0;
        end
        else if (state_reg == sbhs_pkg::FR_DIV)
        begin
            if (!trial[DW])
                rem_reg <= trial[DW-1:0];
            else
                rem_reg <= {rem_reg[DW-2:0], quo_reg[KW-1]};
            quo_reg <= {quo_reg[KW-2:0], 1'b0};
            cnt_reg <= cnt_reg + KCW'(1);
        end
    end

endmodule

// ----- rtl/sbhs_queue.sv -----
// Two-entry queue between the front end and the back end.
module sbhs_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);

    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

// ----- rtl/sbhs_back.sv -----
// Back end: bucket scan, ordered shift, fill update and rank prefix sum.
module sbhs_back #(
    parameter int MAX_BUCKETS      = sbhs_pkg::MAX_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = sbhs_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int KEY_BITS         = sbhs_pkg::KEY_BITS_DEF,
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    localparam int KW = (KEY_BITS < sbhs_pkg::KEY_W) ? KEY_BITS : sbhs_pkg::KEY_W,
    localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1,
    localparam int FW = $clog2(SLOTS_PER_BUCKET + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [sbhs_pkg::OPCODE_W-1:0] q_op,
    input  logic [KW-1:0]                 q_key,
    input  logic [BW-1:0]                 q_bucket,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sbhs_pkg::out_item_t           out_data
);

    localparam int AW = BW + SW;
    localparam int BCW = BW + 1;

    sbhs_pkg::back_state_t state_reg, state_next;

    logic [KW-1:0] slots [MAX_BUCKETS * SLOTS_PER_BUCKET];
    logic [FW-1:0] fill_reg [MAX_BUCKETS];

    logic [sbhs_pkg::OPCODE_W-1:0] op_reg;
    logic [KW-1:0]   key_reg;
    logic [BW-1:0]   bkt_reg;
    logic [FW-1:0]   fill_cur_reg;
    logic [FW-1:0]   pos_reg;
    logic            hit_reg;
    logic [FW-1:0]   idx_reg;
    logic [KW-1:0]   rd_reg;
    logic [BCW-1:0]  sb_reg;
    logic [sbhs_pkg::RANK_W-1:0] sum_reg;
    logic [sbhs_pkg::STATUS_W-1:0] st_reg;

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [KW-1:0]   mem_wd;
    logic [AW-1:0]   mem_ra;

    function automatic logic [AW-1:0] addr(input logic [BW-1:0] b, input logic [FW-1:0] i);
        return AW'(b) * AW'(SLOTS_PER_BUCKET) + AW'(i);
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbhs_pkg::BK_IDLE:     if (q_valid) state_next = sbhs_pkg::BK_SCAN_RD;
            sbhs_pkg::BK_SCAN_RD:
                if (idx_reg >= fill_cur_reg) state_next = sbhs_pkg::BK_DECIDE;
                else state_next = sbhs_pkg::BK_SCAN_CHK;
            sbhs_pkg::BK_SCAN_CHK:
                if (rd_reg >= key_reg) state_next = sbhs_pkg::BK_DECIDE;
                else state_next = sbhs_pkg::BK_SCAN_RD;
            sbhs_pkg::BK_DECIDE:
            begin
                case (op_reg)
                    sbhs_pkg::OP_INSERT:
                        if (hit_reg || fill_cur_reg >= FW'(SLOTS_PER_BUCKET))
                            state_next = sbhs_pkg::BK_OUT;
                        else
                            state_next = sbhs_pkg::BK_INS_RD;
                    sbhs_pkg::OP_DELETE:
                        state_next = hit_reg ? sbhs_pkg::BK_DEL_RD : sbhs_pkg::BK_OUT;
                    sbhs_pkg::OP_QUERY:
                        state_next = hit_reg ? sbhs_pkg::BK_SUM : sbhs_pkg::BK_OUT;
                    default: state_next = sbhs_pkg::BK_OUT;
                endcase
            end
            sbhs_pkg::BK_INS_RD:
                state_next = (idx_reg > pos_reg) ? sbhs_pkg::BK_INS_WR : sbhs_pkg::BK_PUT;
            sbhs_pkg::BK_INS_WR:   state_next = sbhs_pkg::BK_INS_RD;
            sbhs_pkg::BK_PUT:      state_next = sbhs_pkg::BK_OUT;
            sbhs_pkg::BK_DEL_RD:
                state_next = (idx_reg + FW'(1) < fill_cur_reg) ? sbhs_pkg::BK_DEL_WR
                                                               : sbhs_pkg::BK_OUT;
            sbhs_pkg::BK_DEL_WR:   state_next = sbhs_pkg::BK_DEL_RD;
            sbhs_pkg::BK_SUM:
                if (sb_reg >= BCW'(bkt_reg)) state_next = sbhs_pkg::BK_OUT;
            sbhs_pkg::BK_OUT:      if (out_ready) state_next = sbhs_pkg::BK_IDLE;
            default:               state_next = sbhs_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready   = (state_reg == sbhs_pkg::BK_IDLE);
        out_valid = (state_reg == sbhs_pkg::BK_OUT);
        out_data.status = st_reg;
        out_data.rank   = (st_reg == sbhs_pkg::ST_OK && op_reg == sbhs_pkg::OP_QUERY)
                          ? sum_reg : '0;
        mem_we = 1'b0;
        mem_wa = addr(bkt_reg, idx_reg);
        mem_wd = rd_reg;
        mem_ra = addr(bkt_reg, idx_reg);
        case (state_reg)
            sbhs_pkg::BK_INS_RD: mem_ra = addr(bkt_reg, idx_reg - FW'(1));
            sbhs_pkg::BK_INS_WR: mem_we = 1'b1;
            sbhs_pkg::BK_DEL_RD: mem_ra = addr(bkt_reg, idx_reg + FW'(1));
            sbhs_pkg::BK_DEL_WR: mem_we = 1'b1;
            sbhs_pkg::BK_PUT:
            begin
                mem_we = 1'b1;
                mem_wa = addr(bkt_reg, pos_reg);
                mem_wd = key_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slots[mem_wa] <= mem_wd;
        rd_reg <= slots[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbhs_pkg::BK_IDLE;
            for (int i = 0; i < MAX_BUCKETS; i++)
                fill_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sbhs_pkg::BK_PUT)
                fill_reg[bkt_reg] <= fill_cur_reg + FW'(1);
            else if (state_reg == sbhs_pkg::BK_DECIDE && op_reg == sbhs_pkg::OP_DELETE
                     && hit_reg)
                fill_reg[bkt_reg] <= fill_cur_reg - FW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sbhs_pkg::BK_IDLE:
                if (q_valid)
                begin
                    op_reg       <= q_op;
                    key_reg      <= q_key;
                    bkt_reg      <= q_bucket;
                    fill_cur_reg <= fill_reg[q_bucket];
                    idx_reg      <= '0;
                    hit_reg      <= 1'b0;
                end
            sbhs_pkg::BK_SCAN_RD:
                if (idx_reg >= fill_cur_reg)
                    pos_reg <= idx_reg;
            sbhs_pkg::BK_SCAN_CHK:
                if (rd_reg >= key_reg)
                begin
                    pos_reg <= idx_reg;
                    hit_reg <= (rd_reg == key_reg);
                end
                else
                    idx_reg <= idx_reg + FW'(1);
            sbhs_pkg::BK_DECIDE:
            begin
                sb_reg  <= '0;
                sum_reg <= sbhs_pkg::RANK_W'(pos_reg);
                st_reg  <= sbhs_pkg::ST_OK;
                case (op_reg)
                    sbhs_pkg::OP_INSERT:
                    begin
                        idx_reg <= fill_cur_reg;
                        if (hit_reg)
                            st_reg <= sbhs_pkg::ST_MISS;
                        else if (fill_cur_reg >= FW'(SLOTS_PER_BUCKET))
                            st_reg <= sbhs_pkg::ST_FULL;
                    end
                    sbhs_pkg::OP_DELETE, sbhs_pkg::OP_QUERY:
                    begin
                        idx_reg <= pos_reg;
                        if (!hit_reg)
                            st_reg <= sbhs_pkg::ST_MISS;
                    end
                    default: ;
                endcase
            end
            sbhs_pkg::BK_INS_WR: idx_reg <= idx_reg - FW'(1);
            sbhs_pkg::BK_DEL_WR: idx_reg <= idx_reg + FW'(1);
            sbhs_pkg::BK_SUM:
                if (sb_reg < BCW'(bkt_reg))
                begin
                    sum_reg <= sum_reg + sbhs_pkg::RANK_W'(fill_reg[sb_reg[BW-1:0]]);
                    sb_reg  <= sb_reg + BCW'(1);
                end
            default: ;
        endcase
    end

    property p_fill_bound;
        @(posedge clk) disable iff (!rst_n)
        state_reg == sbhs_pkg::BK_PUT |-> fill_cur_reg < FW'(SLOTS_PER_BUCKET);
    endproperty
    assert property (p_fill_bound) else $error("insert into full bucket");

    property p_delete_hit;
        @(posedge clk) disable iff (!rst_n)
        state_reg == sbhs_pkg::BK_DEL_RD |-> hit_reg;
    endproperty
    assert property (p_delete_hit) else $error("delete without a match");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data);
    endproperty
    assert property (p_out_hold) else $error("result changed while stalled");

endmodule

// ----- rtl/sorted_bucket_hash_set_rank_unit.sv -----
// Top level: sorted bucket hash set with dense rank query.
//  channel | signals                      | direction
//  cfg     | cfg_valid cfg_ready cfg_data | in
//  in      | in_valid in_ready in_data    | in
//  out     | out_valid out_ready out_data | out
// Front end: bit-serial bucket modulo; a new item is taken only once the last one is queued.
// Back end: scans slots in order, shifts slots on insert and delete, sums fills of lower buckets.
// A query's rank is the sum of all lower bucket fills plus the position of the match.
// Reset clears all bucket fills at once; no clearing pass. Either side stalls alone.
module sorted_bucket_hash_set_rank_unit #(
    parameter int MAX_BUCKETS      = sbhs_pkg::MAX_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = sbhs_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int KEY_BITS         = sbhs_pkg::KEY_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sbhs_pkg::NB_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  sbhs_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output sbhs_pkg::out_item_t          out_data
);

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int KW = (KEY_BITS < sbhs_pkg::KEY_W) ? KEY_BITS : sbhs_pkg::KEY_W;
    localparam int QW = sbhs_pkg::OPCODE_W + KW + BW;

    logic [sbhs_pkg::NB_W-1:0] nb_reg;
    logic f_valid, f_ready, b_valid, b_ready;
    logic [sbhs_pkg::OPCODE_W-1:0] f_op, b_op;
    logic [KW-1:0] f_key, b_key;
    logic [BW-1:0] f_bkt, b_bkt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nb_reg <= sbhs_pkg::NB_W'(64);
        else if (cfg_valid)
            nb_reg <= cfg_data;
    end

    sbhs_front #(.MAX_BUCKETS(MAX_BUCKETS), .KEY_BITS(KEY_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data), .nb(nb_reg),
        .q_valid(f_valid), .q_ready(f_ready),
        .q_op(f_op), .q_key(f_key), .q_bucket(f_bkt)
    );

    sbhs_queue #(.W(QW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data({f_op, f_key, f_bkt}),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data({b_op, b_key, b_bkt})
    );

    sbhs_back #(
        .MAX_BUCKETS(MAX_BUCKETS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET), .KEY_BITS(KEY_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_ready(b_ready),
        .q_op(b_op), .q_key(b_key), .q_bucket(b_bkt),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule

// ----- verif/tb.sv -----
// Testbench for the sorted bucket hash set rank unit: directed table plus random operations.
module tb;

    localparam int NBKT  = 64;
    localparam int NSLOT = 8;

    typedef struct {
        logic          is_cfg;
        logic [1:0]    opcode;
        logic [31:0]   key;
        logic [6:0]    cfg_val;
        logic          has_exp;
        logic [1:0]    exp_status;
        logic [8:0]    exp_rank;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [sbhs_pkg::NB_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    sbhs_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sbhs_pkg::out_item_t out_data;

    logic [31:0] set_keys [NBKT*NSLOT];
    int unsigned set_fill [NBKT];
    int unsigned bucket_count = 64;
    sbhs_pkg::out_item_t pending_results [$];
    int error_count = 0;
    int hold_off = 0;
    stim_row_t table_rows [$];

    sorted_bucket_hash_set_rank_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    task automatic report(input string what);
        begin
            $display("mismatch at %0t: %s", $realtime, what);
            error_count++;
        end
    endtask

    function automatic sbhs_pkg::out_item_t apply_op(input logic [1:0] op,
                                                     input logic [31:0] k);
        int unsigned b;
        int unsigned pos;
        int unsigned fill;
        int unsigned base;
        int unsigned sum;
        bit hit;
        sbhs_pkg::out_item_t r;
        begin
            r = '0;
            r.status = sbhs_pkg::ST_OK;
            b = k % bucket_count;
            base = b * NSLOT;
            fill = set_fill[b];
            pos = 0;
            while (pos < fill && set_keys[base+pos] < k)
                pos++;
            hit = pos < fill && set_keys[base+pos] == k;
            if (op == sbhs_pkg::OP_INSERT)
            begin
                if (hit)
                    r.status = sbhs_pkg::ST_MISS;
                else if (fill >= NSLOT)
                    r.status = sbhs_pkg::ST_FULL;
                else
                begin
                    for (int i = fill; i > pos; i--)
                        set_keys[base+i] = set_keys[base+i-1];
                    set_keys[base+pos] = k;
                    set_fill[b] = fill + 1;
                end
            end
            else if (op == sbhs_pkg::OP_DELETE)
            begin
                if (hit)
                begin
                    for (int i = pos; i + 1 < fill; i++)
                        set_keys[base+i] = set_keys[base+i+1];
                    set_fill[b] = fill - 1;
                end
                else
                    r.status = sbhs_pkg::ST_MISS;
            end
            else if (op == sbhs_pkg::OP_QUERY)
            begin
                if (hit)
                begin
                    sum = 0;
                    for (int i = 0; i < b; i++)
                        sum += set_fill[i];
                    r.rank = 9'(sum + pos);
                end
                else
                    r.status = sbhs_pkg::ST_MISS;
            end
            return r;
        end
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [31:0] k);
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data <= '{opcode: op, key: k};
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            pending_results.push_back(apply_op(op, k));
            @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(negedge clk);
            repeat (150) @(negedge clk);
        end
    endtask

    task automatic write_buckets(input logic [6:0] v);
        begin
            wait_idle();
            cfg_valid <= 1'b1;
            cfg_data <= v;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            bucket_count = (v == 0) ? 1 : (v > NBKT ? NBKT : v);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    function automatic stim_row_t op_row(input logic [1:0] op, input logic [31:0] k,
                                         input logic chk, input logic [1:0] st,
                                         input logic [8:0] rk);
        stim_row_t s;
        begin
            s = '{is_cfg: 1'b0, opcode: op, key: k, cfg_val: '0,
                  has_exp: chk, exp_status: st, exp_rank: rk};
            return s;
        end
    endfunction

    function automatic stim_row_t cfg_row(input logic [6:0] v);
        stim_row_t s;
        begin
            s = '{is_cfg: 1'b1, opcode: '0, key: '0, cfg_val: v,
                  has_exp: 1'b0, exp_status: '0, exp_rank: '0};
            return s;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report("result with nothing expected");
            else
            begin
                sbhs_pkg::out_item_t e;
                e = pending_results.pop_front();
                if (out_data.status !== e.status)
                    report($sformatf("status %0d, expected %0d", out_data.status, e.status));
                if (out_data.rank !== e.rank)
                    report($sformatf("rank %0d, expected %0d", out_data.rank, e.rank));
            end
        end
    end

    initial
    begin
        int phase;
        begin
            phase = 0;
            forever
            begin
                @(negedge clk);
                phase++;
                if (hold_off > 0)
                begin
                    out_ready <= 1'b0;
                    hold_off--;
                end
                else if (phase % 200 < 60)
                    out_ready <= 1'b1;
                else
                    out_ready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    initial
    begin
        stim_row_t row;
        sbhs_pkg::out_item_t got_exp;
        logic [31:0] pool [16];
        logic [1:0] op;
        logic [31:0] k;
        begin
            for (int i = 0; i < NBKT; i++)
                set_fill[i] = 0;
            repeat (4) @(posedge clk);
            @(negedge clk);
            rst_n <= 1'b1;

            table_rows.push_back(op_row(sbhs_pkg::OP_QUERY, 32'd5, 1'b1,
                                        sbhs_pkg::ST_MISS, 9'd0));
            table_rows.push_back(op_row(sbhs_pkg::OP_DELETE, 32'd5, 1'b1,
                                        sbhs_pkg::ST_MISS, 9'd0));
            table_rows.push_back(op_row(sbhs_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1,
                                        sbhs_pkg::ST_OK, 9'd0));
            table_rows.push_back(op_row(sbhs_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1,
                                        sbhs_pkg::ST_MISS, 9'd0));
            table_rows.push_back(op_row(sbhs_pkg::OP_INSERT, 32'd0, 1'b1,
                                        sbhs_pkg::ST_OK, 9'd0));
            table_rows.push_back(op_row(sbhs_pkg::OP_QUERY, 32'd0, 1'b1,
                                        sbhs_pkg::ST_OK, 9'd0));
            table_rows.push_back(op_row(sbhs_pkg::OP_QUERY, 32'hFFFF_FFFF, 1'b1,
                                        sbhs_pkg::ST_OK, 9'd1));
            table_rows.push_back(op_row(2'd3, 32'd7, 1'b1, sbhs_pkg::ST_OK, 9'd0));
            for (int i = 0; i < 9; i++)
                table_rows.push_back(op_row(sbhs_pkg::OP_INSERT, 32'(64 * (9 - i) + 1),
                                            1'b0, '0, '0));
            table_rows.push_back(op_row(sbhs_pkg::OP_INSERT, 32'd65, 1'b1,
                                        sbhs_pkg::ST_FULL, 9'd0));
            table_rows.push_back(op_row(sbhs_pkg::OP_QUERY, 32'd65, 1'b0, '0, '0));
            table_rows.push_back(op_row(sbhs_pkg::OP_DELETE, 32'd129, 1'b0, '0, '0));
            table_rows.push_back(cfg_row(7'd0));
            table_rows.push_back(op_row(sbhs_pkg::OP_QUERY, 32'd65, 1'b0, '0, '0));
            table_rows.push_back(cfg_row(7'd127));
            table_rows.push_back(op_row(sbhs_pkg::OP_QUERY, 32'hFFFF_FFFF, 1'b0, '0, '0));

            foreach (table_rows[i])
            begin
                row = table_rows[i];
                if (row.is_cfg)
                    write_buckets(row.cfg_val);
                else
                begin
                    send_item(row.opcode, row.key);
                    if (row.has_exp)
                    begin
                        got_exp = pending_results[$];
                        if (got_exp.status !== row.exp_status || got_exp.rank !== row.exp_rank)
                            report("predictor disagrees with table row");
                    end
                end
            end

            for (int p = 0; p < 5; p++)
            begin
                case (p)
                    0: write_buckets(7'd1);
                    1: write_buckets(7'd64);
                    2: write_buckets(7'($urandom_range(2, 63)));
                    3: write_buckets(7'($urandom_range(65, 127)));
                    default: write_buckets(7'd3);
                endcase
                for (int i = 0; i < 16; i++)
                    pool[i] = (i < 4) ? $urandom() : 32'($urandom_range(0, 300));
                if (p == 1)
                    hold_off = 400;
                for (int n = 0; n < 110; n++)
                begin
                    k = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, 15)];
                    op = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                    if (n < 40 && $urandom_range(0, 1))
                        op = sbhs_pkg::OP_INSERT;
                    send_item(op, k);
                end
            end

            wait_idle();
            if (error_count == 0)
                $display("tb: success");
            else
                $display("tb: failure");
            $finish;
        end
    end
endmodule

// ----- filelist.f -----
rtl/sbhs_pkg.sv
rtl/sbhs_front.sv
rtl/sbhs_queue.sv
rtl/sbhs_back.sv
rtl/sorted_bucket_hash_set_rank_unit.sv
verif/tb.sv
